// ===== hdl/bfiq_pkg.sv =====
package bfiq_pkg;

    localparam int FILTER_BITS_DEF = 65536;
    localparam int MAX_PROBES_DEF  = 16;

    localparam int SIZE_W  = 17;
    localparam int COUNT_W = 5;
    localparam int KEY_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [31:0] MIX_C1 = 32'h2c1b3c6d;
    localparam logic [31:0] MIX_C2 = 32'h297a2d39;
    localparam int MIX_SH_A = 15;
    localparam int MIX_SH_B = 12;
    localparam int KEY_SH   = 19;
    localparam int IDX_SH   = 7;

    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS = 32 / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic REG_FILTER_SIZE = 1'b0;
    localparam logic REG_HASH_COUNT  = 1'b1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_DIV,
        S_MEM,
        S_CHK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic mix1;
        logic mix2;
        logic mix3;
        logic div_step;
        logic mem_wr;
        logic hit_clr;
        logic idx_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic k_zero;
        logic is_query;
        logic last_probe;
        logic div_done;
        logic bit_set;
        logic out_free;
    } t_status;

endpackage

// ===== hdl/bfiq_ctrl.sv =====
module bfiq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  bfiq_pkg::t_status i_status,
    output bfiq_pkg::t_cmd    o_cmd,
    output logic              o_ready
);
    import bfiq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_accept) begin
                    if (!i_status.k_zero) n_state = S_MIX1;
                    else if (i_status.is_query) n_state = S_RESULT;
                end
            end
            S_MIX1: n_state = S_MIX2;
            S_MIX2: n_state = S_MIX3;
            S_MIX3: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) n_state = S_MEM;
            end
            S_MEM: begin
                if (i_status.is_query) n_state = S_CHK;
                else if (i_status.last_probe) n_state = S_IDLE;
                else n_state = S_MIX1;
            end
            S_CHK: begin
                if (!i_status.bit_set || i_status.last_probe) n_state = S_RESULT;
                else n_state = S_MIX1;
            end
            S_RESULT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_accept;
            end
            S_MIX1: o_cmd.mix1 = 1'b1;
            S_MIX2: o_cmd.mix2 = 1'b1;
            S_MIX3: o_cmd.mix3 = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_MEM: begin
                o_cmd.mem_wr  = !i_status.is_query;
                o_cmd.idx_inc = !i_status.is_query;
            end
            S_CHK: begin
                o_cmd.hit_clr = !i_status.bit_set;
                o_cmd.idx_inc = 1'b1;
            end
            S_RESULT: o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== hdl/bfiq_dp.sv =====
module bfiq_dp #(
    parameter int FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF,
    parameter int MAX_PROBES  = bfiq_pkg::MAX_PROBES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bfiq_pkg::t_cmd                i_cmd,
    output bfiq_pkg::t_status             o_status,
    input  logic [bfiq_pkg::SIZE_W-1:0]   i_filter_size,
    input  logic [bfiq_pkg::COUNT_W-1:0]  i_hash_count,
    input  logic                          i_func,
    input  logic [bfiq_pkg::KEY_W-1:0]    i_key,
    output logic                          o_valid,
    input  logic                          i_taken,
    output logic                          o_hit
);
    import bfiq_pkg::*;

    localparam int AW = $clog2(FILTER_BITS);
    localparam int SW = $clog2(FILTER_BITS + 1);
    localparam int KW = $clog2(MAX_PROBES + 1);

    logic [12:0]          r_key;
    logic                 r_func;
    logic [SW-1:0]        r_m;
    logic [KW-1:0]        r_k;
    logic [KW-1:0]        r_idx;
    logic [31:0]          r_p1, r_p2, r_h;
    logic [AW:0]          r_rem;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic                 r_hit;
    logic [AW-1:0]        r_clr;
    logic                 r_rd;
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic                 r_mem [FILTER_BITS];

    logic [SW-1:0] m_eff;
    logic [KW-1:0] k_eff;
    logic [31:0]   w, x1, x2, x3;
    logic [AW:0]   n_rem;
    logic [AW:0]   m_ext;
    logic          we, wdat;
    logic [AW-1:0] waddr;

    always_comb begin
        if (32'(i_filter_size) == 32'd0) m_eff = SW'(1);
        else if (32'(i_filter_size) > 32'(FILTER_BITS)) m_eff = SW'(FILTER_BITS);
        else m_eff = SW'(i_filter_size);
        if (32'(i_hash_count) > 32'(MAX_PROBES)) k_eff = KW'(MAX_PROBES);
        else k_eff = KW'(i_hash_count);
    end

    // Probe word: key low bits on top, probe index above the low seven zeros
    assign w  = (32'(r_key) << KEY_SH) | (32'(12'(r_idx)) << IDX_SH);
    assign x1 = w ^ (w >> MIX_SH_A);
    assign x2 = r_p1 ^ (r_p1 >> MIX_SH_B);
    assign x3 = r_p2 ^ (r_p2 >> MIX_SH_A);
    assign m_ext = (AW+1)'(r_m);

    // Restoring remainder, two bits of the dividend per step
    always_comb begin
        logic [AW:0] t;
        t = r_rem;
        for (int j = 0; j < DIV_BITS_PER_STEP; j++) begin
            t = {t[AW-1:0], r_h[31-j]};
            if (t >= m_ext) t = t - m_ext;
        end
        n_rem = t;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_key[12:0];
            r_func <= i_func;
            r_m    <= m_eff;
            r_k    <= k_eff;
        end
        if (i_cmd.load) r_idx <= '0;
        else if (i_cmd.idx_inc) r_idx <= r_idx + KW'(1);
        if (i_cmd.load) r_hit <= 1'b1;
        else if (i_cmd.hit_clr) r_hit <= 1'b0;
        if (i_cmd.mix1) r_p1 <= 32'(x1 * MIX_C1);
        if (i_cmd.mix2) r_p2 <= 32'(x2 * MIX_C2);
        if (i_cmd.mix3) begin
            r_h    <= x3;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_h    <= r_h << DIV_BITS_PER_STEP;
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + DIV_CNT_W'(1);
        end
        if (i_cmd.out_load) r_out_hit <= r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + AW'(1);
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_taken) r_out_valid <= 1'b0;
        end
    end

    assign we    = i_cmd.clr_step | i_cmd.mem_wr;
    assign wdat  = !i_cmd.clr_step;
    assign waddr = i_cmd.clr_step ? r_clr : r_rem[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdat;
        r_rd <= r_mem[r_rem[AW-1:0]];
    end

    always_comb begin
        o_status.clr_done   = (r_clr == AW'(FILTER_BITS - 1));
        o_status.k_zero     = (k_eff == '0);
        o_status.is_query   = (r_func == FUNC_QUERY);
        o_status.last_probe = (r_idx == r_k - KW'(1));
        o_status.div_done   = (r_dcnt == DIV_CNT_W'(DIV_STEPS - 1));
        o_status.bit_set    = r_rd;
        o_status.out_free   = !r_out_valid || i_taken;
    end

    assign o_valid = r_out_valid;
    assign o_hit   = r_out_hit;

endmodule

// ===== hdl/bloom_filter_insert_query.sv =====
// Channel  Dir  Signals                           Word
// s_       in   s_tvalid s_tready s_tdata s_tuser  key in tdata, func in tuser
// m_       out  m_tvalid m_tready m_tdata          hit in tdata[0]
// apb      in   psel penable pwrite paddr pwdata   filter_size @0, hash_count @4
//
// After reset a clearing pass zeroes the bit store, one bit a cycle, over all
// FILTER_BITS bits; no word is accepted until it ends.
// Each probe passes through the mixer states, the remainder steps and one
// store access, plus a check for a query. A query stops at its first clear
// bit. A finished hit waits in the output register; the next word is accepted
// while it waits, and a later query holds in its result state until the
// register frees.
module bloom_filter_insert_query #(
    parameter int FILTER_BITS = bfiq_pkg::FILTER_BITS_DEF,
    parameter int MAX_PROBES  = bfiq_pkg::MAX_PROBES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bfiq_pkg::KEY_W-1:0]    s_tdata,   // [31:0] key
    input  logic                          s_tuser,   // [0] func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [0] hit, [7:1] zero
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfiq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import bfiq_pkg::*;

    logic [SIZE_W-1:0]  r_filter_size;
    logic [COUNT_W-1:0] r_hash_count;
    t_cmd    cmd;
    t_status status;
    logic    hit;
    logic    wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_size <= SIZE_W'(65536);
            r_hash_count  <= COUNT_W'(7);
        end else if (wr) begin
            case (paddr[2])
                REG_FILTER_SIZE: r_filter_size <= pwdata[SIZE_W-1:0];
                REG_HASH_COUNT:  r_hash_count  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FILTER_SIZE: prdata = 32'(r_filter_size);
            REG_HASH_COUNT:  prdata = 32'(r_hash_count);
            default:         prdata = '0;
        endcase
    end

    bfiq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_tvalid & s_tready),
        .i_status (status),
        .o_cmd    (cmd),
        .o_ready  (s_tready)
    );

    bfiq_dp #(
        .FILTER_BITS (FILTER_BITS),
        .MAX_PROBES  (MAX_PROBES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_filter_size (r_filter_size),
        .i_hash_count  (r_hash_count),
        .i_func        (s_tuser),
        .i_key         (s_tdata),
        .o_valid       (m_tvalid),
        .i_taken       (m_tready),
        .o_hit         (hit)
    );

    assign m_tdata = {7'b0, hit};

endmodule

// ===== tb/bloom_filter_insert_query_tb.sv =====
module bloom_filter_insert_query_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfiq_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int STORE_AW       = $clog2(FILTER_BITS_DEF);

    class hit_scoreboard;
        bit          filter_store [FILTER_BITS_DEF];
        int unsigned size_reg;
        int unsigned count_reg;
        bit          hit_queue [$];
        int          errors;
        int          queries;
        int          inserts;

        function void clear_store();
            filter_store = '{default: 1'b0};
            size_reg  = 65536;
            count_reg = 7;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_FILTER_SIZE) begin
                size_reg = 32'(value[SIZE_W-1:0]);
            end else begin
                count_reg = 32'(value[COUNT_W-1:0]);
            end
        endfunction

        function logic [31:0] scramble(logic [31:0] x);
            x = x ^ (x >> MIX_SH_A);
            x = x * MIX_C1;
            x = x ^ (x >> MIX_SH_B);
            x = x * MIX_C2;
            x = x ^ (x >> MIX_SH_A);
            return x;
        endfunction

        function void note_word(logic func, logic [31:0] key);
            int unsigned m;
            int unsigned k;
            int unsigned pos;
            logic [31:0] w;
            bit          hit;
            m = (size_reg == 0) ? 1 : size_reg;
            if (m > FILTER_BITS_DEF) m = FILTER_BITS_DEF;
            k = (count_reg > MAX_PROBES_DEF) ? MAX_PROBES_DEF : count_reg;
            hit = 1'b1;
            for (int unsigned i = 0; i < k; i++) begin
                w = (key << KEY_SH) | (i << IDX_SH);
                pos = scramble(w) % m;
                if (func == FUNC_INSERT) begin
                    filter_store[pos[STORE_AW-1:0]] = 1'b1;
                end else if (!filter_store[pos[STORE_AW-1:0]]) begin
                    hit = 1'b0;
                end
            end
            if (func == FUNC_QUERY) begin
                hit_queue.push_back(hit);
                queries++;
            end else begin
                inserts++;
            end
        endfunction

        function void check_hit(logic [7:0] data);
            bit exp_hit;
            if (hit_queue.size() == 0) begin
                $error("unexpected result word: hit actual %0d", data[0]);
                errors++;
                return;
            end
            exp_hit = hit_queue.pop_front();
            if (data[0] !== exp_hit) begin
                $error("field hit: expected %0d, actual %0d", exp_hit, data[0]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [KEY_W-1:0] s_tdata = '0;    // [31:0] key
    logic s_tuser = 1'b0;              // [0] func
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;               // [0] hit, [7:1] zero
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hit_scoreboard sb = new();
    int  idle_cycles;
    bit  sink_gaps = 1'b1;
    bit  sink_hold = 1'b0;
    int  hold_len = 0;

    always #5 i_clk = ~i_clk;

    bloom_filter_insert_query u_top (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_hit(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, or one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (sink_hold && hold_len > 0) begin
                m_tready <= 1'b0;
                hold_len = hold_len - 1;
                if (hold_len == 0) sink_hold = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send_word(logic func, logic [31:0] key, bit gaps);
        if (gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1; s_tuser <= func; s_tdata <= key;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_word(func, key);
    endtask

    task automatic quiesce();
        // drop valid at the accept edge so the last word is not taken twice
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly insert-then-query of the same keys; low 13 bits matter
    task automatic random_phase(int n, bit gaps);
        logic [31:0] keys [$];
        logic [31:0] key;
        logic [18:0] hi;
        logic func;
        for (int i = 0; i < n; i++) begin
            func = 1'($urandom_range(0, 1));
            if (func == FUNC_QUERY && keys.size() > 0 && $urandom_range(0, 2) != 0) begin
                hi = $urandom_range(0, 1) ? 19'h0 : 19'($urandom());
                key = keys[$urandom_range(0, keys.size() - 1)] ^ {hi, 13'h0};
            end else begin
                key = $urandom();
                if ($urandom_range(0, 3) == 0) key[12:0] = 13'($urandom_range(0, 31));
            end
            if (func == FUNC_INSERT) keys.push_back(key);
            send_word(func, key, gaps);
        end
    endtask

    initial begin
        sb.clear_store();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, field extremes
        send_word(FUNC_QUERY, 32'h0000_0000, 1'b0);
        send_word(FUNC_INSERT, 32'h0000_0000, 1'b0);
        send_word(FUNC_QUERY, 32'h0000_0000, 1'b0);
        send_word(FUNC_INSERT, 32'hFFFF_FFFF, 1'b0);
        send_word(FUNC_QUERY, 32'hFFFF_FFFF, 1'b0);
        send_word(FUNC_QUERY, 32'h0000_1FFF, 1'b0);
        send_word(FUNC_QUERY, 32'hAAAA_5555, 1'b0);
        quiesce();
        // zero probes: always a hit, inserts change nothing
        write_reg(REG_HASH_COUNT, 32'd0);
        send_word(FUNC_INSERT, 32'h1234_5678, 1'b0);
        send_word(FUNC_QUERY, 32'h5555_AAAA, 1'b0);
        quiesce();
        // size zero acts as one, probe count saturates
        write_reg(REG_FILTER_SIZE, 32'd0);
        write_reg(REG_HASH_COUNT, 32'h1F);
        send_word(FUNC_QUERY, 32'h0000_0042, 1'b0);
        send_word(FUNC_INSERT, 32'h0000_0042, 1'b0);
        send_word(FUNC_QUERY, 32'h0000_0777, 1'b0);
        quiesce();
        // size above the store saturates
        write_reg(REG_FILTER_SIZE, 32'hFFFF_FFFF);
        write_reg(REG_HASH_COUNT, 32'd16);
        send_word(FUNC_INSERT, 32'h0000_0100, 1'b0);
        send_word(FUNC_QUERY, 32'h0000_0100, 1'b0);
        send_word(FUNC_QUERY, 32'h0000_0101, 1'b0);
        quiesce();

        write_reg(REG_FILTER_SIZE, 32'd97);
        write_reg(REG_HASH_COUNT, 32'd3);
        random_phase(200, 1'b1);
        quiesce();

        // long receiver hold-off while the sender keeps offering
        write_reg(REG_FILTER_SIZE, 32'd1);
        write_reg(REG_HASH_COUNT, 32'd1);
        hold_len = 400;
        sink_hold = 1'b1;
        random_phase(20, 1'b0);
        quiesce();

        write_reg(REG_FILTER_SIZE, 32'd65536);
        write_reg(REG_HASH_COUNT, 32'd5);
        random_phase(200, 1'b1);
        quiesce();

        write_reg(REG_FILTER_SIZE, 32'd4096);
        write_reg(REG_HASH_COUNT, 32'd2);
        random_phase(150, 1'b1);
        quiesce();

        // last part without idling on either side
        sink_gaps = 1'b0;
        write_reg(REG_FILTER_SIZE, 32'd33333);
        write_reg(REG_HASH_COUNT, 32'd4);
        random_phase(150, 1'b0);
        quiesce();

        $display("Covered %0d inserts and %0d queries", sb.inserts, sb.queries);
        $display("over sizes 0..65536+ and probe counts 0..31.");
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/bfiq_pkg.sv
hdl/bfiq_ctrl.sv
hdl/bfiq_dp.sv
hdl/bloom_filter_insert_query.sv
tb/bloom_filter_insert_query_tb.sv
